>>> rtl/bbmp_pkg.sv
// Package with the widths, types, register codes and state encoding of the box merge pass.
`timescale 1ns / 1ps
`default_nettype none

package bbmp_pkg;

  localparam int MAX_BOXES  = 32;
  localparam int COORD_BITS = 12;

  localparam int POS_W  = COORD_BITS;
  localparam int LEN_W  = COORD_BITS + 1;
  localparam int EXT_W  = COORD_BITS + 2;
  localparam int SUM_W  = EXT_W + 1;
  localparam int IDX_W  = $clog2(MAX_BOXES);
  localparam int CNT_W  = $clog2(MAX_BOXES + 1);

  localparam int EXP_W      = 8;
  localparam int MIN_KEEP_W = 12;
  localparam int KCMP_W     = (EXT_W > MIN_KEEP_W) ? EXT_W : MIN_KEEP_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_EXPAND_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPAND_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_KEEP = 2'd2;

  localparam logic [EXP_W-1:0]      EXPAND_X_RST = 8'd20;
  localparam logic [EXP_W-1:0]      EXPAND_Y_RST = 8'd8;
  localparam logic [MIN_KEEP_W-1:0] MIN_KEEP_RST = 12'd10;

  // Table entries hold the right and bottom edges rather than the extents.
  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [EXT_W-1:0] x2;
    logic [EXT_W-1:0] y2;
  } tbl_entry_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [LEN_W-1:0] w;
    logic [LEN_W-1:0] h;
  } res_t;

  localparam int TBL_W = $bits(tbl_entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_HEAD,
    ST_SCAN,
    ST_WB,
    ST_DONE
  } st_t;

endpackage

`default_nettype wire

>>> rtl/bounding_box_merge_pass.sv
// Boxes are loaded while the block is idle; in_stall is high from the list end until the
// pass hands over its last result. Each box not yet absorbed is compared with every other
// box in the table, absorbs those its enlarged outline touches and is written back, the
// write-back waiting while a stalled output holds an earlier result. The single read port
// of the box table paces the pass, delivering one partner box per cycle to the overlap and
// union stage. Reset (synchronous, active low) empties the list, clears the used marks and
// the drop flag and restores the registers to their defaults; the box table is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module bounding_box_merge_pass
  import bbmp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,

  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [POS_W-1:0]      in_box_x,
  input  wire logic [POS_W-1:0]      in_box_y,
  input  wire logic [LEN_W-1:0]      in_box_w,
  input  wire logic [LEN_W-1:0]      in_box_h,
  input  wire logic                  in_list_end,

  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [POS_W-1:0]           out_res_x,
  output logic [POS_W-1:0]           out_res_y,
  output logic [LEN_W-1:0]           out_res_w,
  output logic [LEN_W-1:0]           out_res_h,
  output logic                       out_run_last,
  output logic                       out_any_merged,
  output logic                       out_no_box,
  output logic                       out_overflowed
);

  st_t                   state_r, state_nxt;

  logic [EXP_W-1:0]      exp_x_r, exp_y_r;
  logic [MIN_KEEP_W-1:0] min_keep_r;

  logic [CNT_W-1:0]      cnt_r;
  logic                  drop_r;
  logic                  merged_r;
  logic [MAX_BOXES-1:0]  used_r;
  logic [CNT_W-1:0]      i_r;
  logic [CNT_W-1:0]      ja_r;
  logic                  cmp_v_r;
  logic [IDX_W-1:0]      cmp_j_r;
  tbl_entry_t            cur_r;
  logic                  pend_v_r;
  res_t                  pend_r;

  logic                  out_valid_r;
  res_t                  out_r;
  logic                  out_last_r, out_merged_r, out_nobox_r, out_ovf_r;
  logic                  out_load;

  logic [TBL_W-1:0]      mem [MAX_BOXES];
  logic [TBL_W-1:0]      rd_data_r;
  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_wa, mem_ra;
  tbl_entry_t            mem_wd;
  tbl_entry_t            part;

  logic                  in_acc, has_room, out_free, wb_wait, keep;
  logic [POS_W-1:0]      lft, top;
  logic [SUM_W-1:0]      rgt_a, bot_a, rgt, bot;
  logic                  touch, merge_hit;
  tbl_entry_t            uni;
  logic [EXT_W-1:0]      cur_w, cur_h;
  res_t                  cur_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && (state_r == ST_IDLE);
  assign has_room  = (cnt_r < CNT_W'(MAX_BOXES));
  assign out_free  = !out_valid_r || !out_stall;
  assign part      = tbl_entry_t'(rd_data_r);

  // Overlap test of the enlarged current box against the partner, and their union.
  always_comb begin
    lft   = (cur_r.x > part.x) ? cur_r.x : part.x;
    top   = (cur_r.y > part.y) ? cur_r.y : part.y;
    rgt_a = SUM_W'(cur_r.x2) + SUM_W'(exp_x_r);
    bot_a = SUM_W'(cur_r.y2) + SUM_W'(exp_y_r);
    rgt   = (rgt_a < SUM_W'(part.x2)) ? rgt_a : SUM_W'(part.x2);
    bot   = (bot_a < SUM_W'(part.y2)) ? bot_a : SUM_W'(part.y2);
    touch = (SUM_W'(lft) < rgt) && (SUM_W'(top) < bot);
    uni.x  = (cur_r.x < part.x) ? cur_r.x : part.x;
    uni.y  = (cur_r.y < part.y) ? cur_r.y : part.y;
    uni.x2 = (cur_r.x2 > part.x2) ? cur_r.x2 : part.x2;
    uni.y2 = (cur_r.y2 > part.y2) ? cur_r.y2 : part.y2;
  end

  assign merge_hit = (state_r == ST_SCAN) && cmp_v_r && touch;

  always_comb begin
    cur_w     = cur_r.x2 - EXT_W'(cur_r.x);
    cur_h     = cur_r.y2 - EXT_W'(cur_r.y);
    keep      = (KCMP_W'(cur_w) > KCMP_W'(min_keep_r)) &&
                (KCMP_W'(cur_h) > KCMP_W'(min_keep_r));
    cur_res.x = cur_r.x;
    cur_res.y = cur_r.y;
    cur_res.w = cur_w[LEN_W-1:0];
    cur_res.h = cur_h[LEN_W-1:0];
  end

  assign wb_wait  = keep && pend_v_r && !out_free;
  assign out_load = ((state_r == ST_WB) && !wb_wait && keep && pend_v_r) ||
                    ((state_r == ST_DONE) && out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mem_re    = 1'b0;
    mem_ra    = ja_r[IDX_W-1:0];
    mem_we    = 1'b0;
    mem_wa    = cnt_r[IDX_W-1:0];
    mem_wd.x  = in_box_x;
    mem_wd.y  = in_box_y;
    mem_wd.x2 = EXT_W'(in_box_x) + EXT_W'(in_box_w);
    mem_wd.y2 = EXT_W'(in_box_y) + EXT_W'(in_box_h);
    unique case (state_r)
      ST_IDLE: begin
        mem_we = in_acc && has_room;
        if (in_acc && in_list_end) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (i_r >= cnt_r) begin
          state_nxt = ST_DONE;
        end else if (!used_r[i_r[IDX_W-1:0]]) begin
          mem_re    = 1'b1;
          mem_ra    = i_r[IDX_W-1:0];
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: begin
        mem_re    = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        mem_re = (ja_r < cnt_r);
        if (ja_r >= cnt_r) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        mem_we = 1'b1;
        mem_wa = i_r[IDX_W-1:0];
        mem_wd = cur_r;
        if (!wb_wait) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_x_r    <= EXPAND_X_RST;
      exp_y_r    <= EXPAND_Y_RST;
      min_keep_r <= MIN_KEEP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_EXPAND_X: exp_x_r    <= cfg_data[EXP_W-1:0];
        CFG_EXPAND_Y: exp_y_r    <= cfg_data[EXP_W-1:0];
        CFG_MIN_KEEP: min_keep_r <= cfg_data[MIN_KEEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      merged_r    <= 1'b0;
      used_r      <= '0;
      i_r         <= '0;
      ja_r        <= '0;
      cmp_v_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          i_r <= '0;
          if (in_acc) begin
            if (has_room) begin
              cnt_r <= cnt_r + 1'b1;
            end else begin
              drop_r <= 1'b1;
            end
          end
        end
        ST_ISSUE: begin
          ja_r <= '0;
          if (i_r < cnt_r && used_r[i_r[IDX_W-1:0]]) begin
            i_r <= i_r + 1'b1;
          end
        end
        ST_HEAD: begin
          cur_r   <= part;
          cmp_v_r <= (ja_r != i_r);
          cmp_j_r <= ja_r[IDX_W-1:0];
          ja_r    <= ja_r + 1'b1;
        end
        ST_SCAN: begin
          if (merge_hit) begin
            cur_r            <= uni;
            used_r[cmp_j_r]  <= 1'b1;
            merged_r         <= 1'b1;
          end
          if (ja_r < cnt_r) begin
            cmp_v_r <= (ja_r != i_r);
            cmp_j_r <= ja_r[IDX_W-1:0];
            ja_r    <= ja_r + 1'b1;
          end else begin
            cmp_v_r <= 1'b0;
          end
        end
        ST_WB: begin
          if (!wb_wait) begin
            i_r <= i_r + 1'b1;
            if (keep) begin
              pend_r   <= cur_res;
              pend_v_r <= 1'b1;
              if (pend_v_r) begin
                out_r        <= pend_r;
                out_last_r   <= 1'b0;
                out_merged_r <= 1'b0;
                out_nobox_r  <= 1'b0;
                out_ovf_r    <= 1'b0;
              end
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_r        <= pend_v_r ? pend_r : '0;
            out_last_r   <= 1'b1;
            out_merged_r <= merged_r;
            out_nobox_r  <= !pend_v_r;
            out_ovf_r    <= drop_r;
            cnt_r        <= '0;
            drop_r       <= 1'b0;
            merged_r     <= 1'b0;
            used_r       <= '0;
            pend_v_r     <= 1'b0;
            i_r          <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_res_x      = out_r.x;
  assign out_res_y      = out_r.y;
  assign out_res_w      = out_r.w;
  assign out_res_h      = out_r.h;
  assign out_run_last   = out_last_r;
  assign out_any_merged = out_merged_r;
  assign out_no_box     = out_nobox_r;
  assign out_overflowed = out_ovf_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_BOXES))
    else $error("box count exceeds table depth");

  a_no_self: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_v_r |-> (CNT_W'(cmp_j_r) != i_r))
    else $error("box compared with itself");

  a_pass_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (cnt_r == '0 && used_r == '0 && !pend_v_r))
    else $error("list state not cleared after the pass");

  a_nobox_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_box) |-> out_run_last)
    else $error("empty result is not the last transfer of the pass");
`endif

endmodule

`default_nettype wire

>>> test/bounding_box_merge_pass_tb.sv
// Self-checking testbench for the box merge pass; results are predicted or taken from a table.
`timescale 1ns / 1ps

module bounding_box_merge_pass_tb
  import bbmp_pkg::*;
();

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [LEN_W-1:0] w;
    logic [LEN_W-1:0] h;
  } rect_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [LEN_W-1:0] w;
    logic [LEN_W-1:0] h;
    logic             run_last;
    logic             any_merged;
    logic             no_box;
    logic             overflowed;
  } merge_out_t;

  typedef struct packed {
    rect_t      box;
    logic       last;
    logic [5:0] copies;
    logic       literal;
    merge_out_t want;
  } stim_row_t;

  localparam int NROWS = 17;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [POS_W-1:0]      in_box_x = '0;
  logic [POS_W-1:0]      in_box_y = '0;
  logic [LEN_W-1:0]      in_box_w = '0;
  logic [LEN_W-1:0]      in_box_h = '0;
  logic                  in_list_end = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [POS_W-1:0]      out_res_x;
  logic [POS_W-1:0]      out_res_y;
  logic [LEN_W-1:0]      out_res_w;
  logic [LEN_W-1:0]      out_res_h;
  logic                  out_run_last;
  logic                  out_any_merged;
  logic                  out_no_box;
  logic                  out_overflowed;

  // Predictor state: the held boxes keep their full extents, as a union may outgrow the field.
  int                    held_x [MAX_BOXES];
  int                    held_y [MAX_BOXES];
  int                    held_w [MAX_BOXES];
  int                    held_h [MAX_BOXES];
  bit                    absorbed [MAX_BOXES];
  int                    held_count = 0;
  bit                    lost_box = 1'b0;
  logic [EXP_W-1:0]      grow_x = EXPAND_X_RST;
  logic [EXP_W-1:0]      grow_y = EXPAND_Y_RST;
  logic [MIN_KEEP_W-1:0] keep_min = MIN_KEEP_RST;

  merge_out_t            boxes_due [$];
  int                    fail_count = 0;
  int                    hold_req = 0;
  bit                    calm_mode = 1'b0;
  bit                    burst_mode = 1'b0;
  stim_row_t             first_rows [NROWS];

  bounding_box_merge_pass uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void predict_merge(input rect_t b, input bit last,
                                        ref merge_out_t found[$]);
    int         cx, cy, cw, ch, jx, jy, jw, jh;
    int         lft, top, rgt, bot, nx, ny, i, j;
    bit         any;
    merge_out_t o;
    found = {};
    if (held_count < MAX_BOXES) begin
      held_x[held_count] = int'(b.x);
      held_y[held_count] = int'(b.y);
      held_w[held_count] = int'(b.w);
      held_h[held_count] = int'(b.h);
      absorbed[held_count] = 1'b0;
      held_count++;
    end else begin
      lost_box = 1'b1;
    end
    if (!last) return;
    any = 1'b0;
    for (i = 0; i < held_count; i++) begin
      if (absorbed[i]) continue;
      cx = held_x[i];
      cy = held_y[i];
      cw = held_w[i];
      ch = held_h[i];
      for (j = 0; j < held_count; j++) begin
        if (j == i) continue;
        jx = held_x[j];
        jy = held_y[j];
        jw = held_w[j];
        jh = held_h[j];
        lft = (cx > jx) ? cx : jx;
        top = (cy > jy) ? cy : jy;
        rgt = (cx + cw + int'(grow_x) < jx + jw) ? cx + cw + int'(grow_x) : jx + jw;
        bot = (cy + ch + int'(grow_y) < jy + jh) ? cy + ch + int'(grow_y) : jy + jh;
        if (lft < rgt && top < bot) begin
          nx = (cx < jx) ? cx : jx;
          ny = (cy < jy) ? cy : jy;
          cw = ((cx + cw > jx + jw) ? cx + cw : jx + jw) - nx;
          ch = ((cy + ch > jy + jh) ? cy + ch : jy + jh) - ny;
          cx = nx;
          cy = ny;
          absorbed[j] = 1'b1;
          any = 1'b1;
        end
      end
      held_x[i] = cx;
      held_y[i] = cy;
      held_w[i] = cw;
      held_h[i] = ch;
      if (cw > int'(keep_min) && ch > int'(keep_min)) begin
        o = '0;
        o.x = cx[POS_W-1:0];
        o.y = cy[POS_W-1:0];
        o.w = cw[LEN_W-1:0];
        o.h = ch[LEN_W-1:0];
        found = {found, o};
      end
    end
    if (found.size() == 0) begin
      o = '0;
      o.no_box = 1'b1;
    end else begin
      o = found.pop_back();
    end
    o.run_last = 1'b1;
    o.any_merged = any;
    o.overflowed = lost_box;
    found = {found, o};
    held_count = 0;
    lost_box = 1'b0;
    absorbed = '{default: 1'b0};
  endfunction

  task automatic send_box(input rect_t b, input bit last, input bit lit, input merge_out_t want);
    int         gap;
    merge_out_t found [$];
    gap = (calm_mode || burst_mode) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_box_x <= b.x;
    in_box_y <= b.y;
    in_box_w <= b.w;
    in_box_h <= b.h;
    in_list_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_merge(b, last, found);
    if (lit && last) begin
      boxes_due = {boxes_due, want};
    end else begin
      boxes_due = {boxes_due, found};
    end
  endtask

  task automatic write_regs(input logic [CFG_DATA_W-1:0] gx, gy, km);
    logic [CFG_IDX_W-1:0]  idx [3];
    logic [CFG_DATA_W-1:0] val [3];
    int                    k;
    idx = '{CFG_EXPAND_X, CFG_EXPAND_Y, CFG_MIN_KEEP};
    val = '{gx, gy, km};
    for (k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[k])
        CFG_EXPAND_X: grow_x = val[k][EXP_W-1:0];
        CFG_EXPAND_Y: grow_y = val[k][EXP_W-1:0];
        default: keep_min = val[k][MIN_KEEP_W-1:0];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (boxes_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  initial begin
    int          stall_left;
    merge_out_t  exp_r;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && !out_stall) begin
        if (boxes_due.size() == 0) begin
          $error("unexpected result transfer: x %0d y %0d w %0d h %0d",
                 out_res_x, out_res_y, out_res_w, out_res_h);
          fail_count++;
        end else begin
          exp_r = boxes_due.pop_front();
          if (out_res_x !== exp_r.x) begin
            $error("res_x: expected %0d, got %0d", exp_r.x, out_res_x);
            fail_count++;
          end
          if (out_res_y !== exp_r.y) begin
            $error("res_y: expected %0d, got %0d", exp_r.y, out_res_y);
            fail_count++;
          end
          if (out_res_w !== exp_r.w) begin
            $error("res_w: expected %0d, got %0d", exp_r.w, out_res_w);
            fail_count++;
          end
          if (out_res_h !== exp_r.h) begin
            $error("res_h: expected %0d, got %0d", exp_r.h, out_res_h);
            fail_count++;
          end
          if (out_run_last !== exp_r.run_last) begin
            $error("run_last: expected %0d, got %0d", exp_r.run_last, out_run_last);
            fail_count++;
          end
          if (out_any_merged !== exp_r.any_merged) begin
            $error("any_merged: expected %0d, got %0d", exp_r.any_merged, out_any_merged);
            fail_count++;
          end
          if (out_no_box !== exp_r.no_box) begin
            $error("no_box: expected %0d, got %0d", exp_r.no_box, out_no_box);
            fail_count++;
          end
          if (out_overflowed !== exp_r.overflowed) begin
            $error("overflowed: expected %0d, got %0d", exp_r.overflowed, out_overflowed);
            fail_count++;
          end
        end
        stall_left = calm_mode ? 0 : $urandom_range(0, 13);
      end
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int    phase, sent, len, pick, bx, by, spin, r, c, k;
    rect_t b;
    first_rows = '{
      '{'{12'd0, 12'd0, 13'd0, 13'd0}, 1'b1, 6'd1, 1'b1,
        '{12'd0, 12'd0, 13'd0, 13'd0, 1'b1, 1'b0, 1'b1, 1'b0}},
      '{'{12'd4095, 12'd4095, 13'd8191, 13'd8191}, 1'b1, 6'd1, 1'b1,
        '{12'd4095, 12'd4095, 13'd8191, 13'd8191, 1'b1, 1'b0, 1'b0, 1'b0}},
      '{'{12'd100, 12'd100, 13'd20, 13'd20}, 1'b0, 6'd1, 1'b0, '0},
      '{'{12'd130, 12'd100, 13'd20, 13'd20}, 1'b1, 6'd1, 1'b1,
        '{12'd100, 12'd100, 13'd50, 13'd20, 1'b1, 1'b1, 1'b0, 1'b0}},
      '{'{12'd0, 12'd0, 13'd50, 13'd50}, 1'b0, 6'd1, 1'b0, '0},
      '{'{12'd70, 12'd0, 13'd50, 13'd50}, 1'b1, 6'd1, 1'b0, '0},
      '{'{12'd0, 12'd0, 13'd10, 13'd20}, 1'b0, 6'd1, 1'b0, '0},
      '{'{12'd100, 12'd0, 13'd10, 13'd20}, 1'b0, 6'd1, 1'b0, '0},
      '{'{12'd25, 12'd0, 13'd80, 13'd20}, 1'b1, 6'd1, 1'b0, '0},
      '{'{12'd0, 12'd0, 13'd0, 13'd0}, 1'b0, 6'd1, 1'b0, '0},
      '{'{12'd5, 12'd2, 13'd30, 13'd30}, 1'b1, 6'd1, 1'b0, '0},
      '{'{12'd0, 12'd0, 13'd11, 13'd11}, 1'b0, 6'd1, 1'b0, '0},
      '{'{12'd2000, 12'd2000, 13'd10, 13'd11}, 1'b1, 6'd1, 1'b1,
        '{12'd0, 12'd0, 13'd11, 13'd11, 1'b1, 1'b0, 1'b0, 1'b0}},
      '{'{12'd4095, 12'd0, 13'd8191, 13'd4096}, 1'b0, 6'd1, 1'b0, '0},
      '{'{12'd0, 12'd4095, 13'd4096, 13'd8191}, 1'b1, 6'd1, 1'b0, '0},
      '{'{12'd10, 12'd10, 13'd40, 13'd40}, 1'b1, 6'd33, 1'b1,
        '{12'd10, 12'd10, 13'd40, 13'd40, 1'b1, 1'b1, 1'b0, 1'b1}},
      '{'{12'd0, 12'd4095, 13'd4096, 13'd0}, 1'b1, 6'd1, 1'b1,
        '{12'd0, 12'd0, 13'd0, 13'd0, 1'b1, 1'b0, 1'b1, 1'b0}}
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < NROWS; r++) begin
      for (c = 0; c < first_rows[r].copies; c++) begin
        send_box(first_rows[r].box, first_rows[r].last && (c == first_rows[r].copies - 1),
                 first_rows[r].literal, first_rows[r].want);
      end
    end

    for (phase = 1; phase <= 6; phase++) begin
      wait_drained();
      case (phase)
        1: write_regs(12'd0, 12'd0, 12'd0);
        2: write_regs(12'd255, 12'd255, 12'd4095);
        3: write_regs(12'hF37, 12'hE05, 12'd300);
        6: write_regs(12'd20, 12'd8, 12'd10);
        default: write_regs(CFG_DATA_W'($urandom_range(0, 4095)),
                            CFG_DATA_W'($urandom_range(0, 4095)),
                            CFG_DATA_W'($urandom_range(0, 60)));
      endcase
      // The output is held off while the inputs arrive back to back, so the block backs up.
      if (phase == 1) begin
        hold_req = 300;
        burst_mode = 1'b1;
      end
      sent = 0;
      while (sent < 53) begin
        pick = $urandom_range(0, 49);
        if (pick == 0) len = $urandom_range(33, 36);
        else if (pick == 1) len = 32;
        else if (pick < 10) len = $urandom_range(17, 31);
        else if (pick < 20) len = $urandom_range(7, 16);
        else len = $urandom_range(1, 6);
        calm_mode = !burst_mode && ($urandom_range(0, 3) == 0);
        bx = $urandom_range(0, 3900);
        by = $urandom_range(0, 3900);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            b.x = POS_W'($urandom_range(0, 4095));
            b.y = POS_W'($urandom_range(0, 4095));
            b.w = LEN_W'($urandom_range(0, 8191));
            b.h = LEN_W'($urandom_range(0, 8191));
          end else begin
            b.x = POS_W'(bx + $urandom_range(0, 150));
            b.y = POS_W'(by + $urandom_range(0, 100));
            b.w = LEN_W'($urandom_range(0, 60));
            b.h = LEN_W'($urandom_range(0, 40));
          end
          send_box(b, k == len - 1, 1'b0, '0);
          sent++;
        end
        if (burst_mode && sent >= 24) burst_mode = 1'b0;
      end
      calm_mode = 1'b0;
    end

    in_valid <= 1'b0;
    spin = 0;
    while (boxes_due.size() != 0 && spin < 100000) begin
      @(posedge clk);
      spin++;
    end
    repeat (40) @(posedge clk);
    if (boxes_due.size() != 0) begin
      $error("%0d expected results never arrived", boxes_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/bbmp_pkg.sv
rtl/bounding_box_merge_pass.sv
test/bounding_box_merge_pass_tb.sv
